/* hdl/sdte_pkg.sv */
// Shared constants, types and register codes of the stereo drive/tone effect.
package sdte_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int QUEUE_DEPTH = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BIAS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TONE  = 3'd4;

   // shaper modes
   localparam logic [1:0] MODE_TANH  = 2'd0;
   localparam logic [1:0] MODE_CUBIC = 2'd1;
   localparam logic [1:0] MODE_FOLD  = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // Q1.15 / Q3.13 control constants
   localparam logic [15:0] UNITY15    = 16'd32768;
   localparam logic [15:0] GAIN_RESET = 16'd8192;
   localparam logic [15:0] K_02       = 16'd6554;
   localparam logic [15:0] K_03       = 16'd9830;
   localparam logic [15:0] K_095      = 16'd31130;
   localparam logic signed [15:0] BIAS_MAX = 16'sd16384;
   localparam logic signed [15:0] BIAS_MIN = -16'sd16384;

   // sample domain constants, 23 fraction bits
   localparam logic signed [26:0] ONE      = 27'sd8388608;
   localparam logic signed [26:0] NEG_ONE  = -27'sd8388608;
   localparam logic signed [26:0] THREE    = 27'sd25165824;
   localparam logic signed [26:0] NEG_THREE = -27'sd25165824;
   localparam logic signed [26:0] T06      = 27'sd5033165;
   localparam logic signed [26:0] NEG_T06  = -27'sd5033165;
   localparam logic [29:0] TWENTY7_ONE = 30'd226492416;
   localparam logic [23:0] SAT_POS = 24'h7FFFFF;
   localparam logic [23:0] SAT_NEG = 24'h800000;

   typedef struct packed {
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
      logic                last;
   } item_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [15:0]        gain;
      logic signed [24:0] bq;
      logic [15:0]        level;
      logic [15:0]        tone;
      logic [15:0]        coef;
   } params_type;

   typedef struct packed {
      logic busy;
      logic pop;
   } back_status_type;

endpackage

/* hdl/sdte_if.sv */
// Request and response channel interfaces.
interface sdte_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] left_sample;
   logic signed [23:0] right_sample;
   logic               block_end;
   modport source (output valid, left_sample, right_sample, block_end, input ready);
   modport sink (input valid, left_sample, right_sample, block_end, output ready);
endinterface

interface sdte_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] left_result;
   logic signed [23:0] right_result;
   logic               block_end_out;
   modport source (output valid, left_result, right_result, block_end_out, input ready);
   modport sink (input valid, left_result, right_result, block_end_out, output ready);
endinterface

/* hdl/stereo_drive_tone_effect.sv */
// Top level of the stereo drive/tone effect: front, request queue and back end.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        left_sample, right_sample, block_end
//   rsp      out  valid/ready        left_result, right_result, block_end_out
//   csr      in   csr_we             csr_index, csr_wdata (write only)
//
// In the back end a stereo pair is two per-channel passes, left then right. In
// the tanh mode a pass within +/-3 also runs the 25-step radix-2 divider,
// which the cubic and foldback modes do not use.
// Reset is synchronous, active high; lowpass state and registers take their
// reset values. The two-entry queue keeps taking requests while
// the back end works, and a finished pair waits in the output register while
// the back end starts the next one if the response side stalls.
module stereo_drive_tone_effect (
   input  logic                            clock,
   input  logic                            reset,
   sdte_req_if.sink                        req,
   sdte_rsp_if.source                      rsp,
   input  logic                            csr_we,
   input  logic [sdte_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sdte_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sdte_pkg::*;

   logic            push;
   item_type        push_item;
   item_type        q_item;
   logic [1:0]      q_count;
   params_type      prm;
   back_status_type status;

   // intake and conditioned parameters
   sdte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_count   (q_count),
      .push      (push),
      .push_item (push_item),
      .prm       (prm)
   );

   // decouples intake from the arithmetic
   sdte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (status.pop),
      .pop_item  (q_item),
      .count     (q_count)
   );

   // shaper, tone filter and output register
   sdte_back u_back (
      .clock   (clock),
      .reset   (reset),
      .prm     (prm),
      .q_item  (q_item),
      .q_valid (q_count != 2'd0),
      .status  (status),
      .rsp     (rsp)
   );

   // queue never holds more than its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count != 2'd3)
      else $error("request queue overflow");

   // back end pops only a filled queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      status.pop |-> q_count != 2'd0)
      else $error("pop from empty request queue");

   // a response appears only at the end of a back-end pass
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(status.busy))
      else $error("response without work in progress");

endmodule

/* hdl/sdte_queue.sv */
// Two-entry request queue between front and back.
module sdte_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sdte_pkg::item_type push_item,
   input  logic              pop,
   output sdte_pkg::item_type pop_item,
   output logic [1:0]        count
);
   import sdte_pkg::*;

   item_type   mem_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = mem_ff[rd_ptr_ff];
   assign count    = count_ff;

endmodule

/* hdl/sdte_front.sv */
// Front end: register file, parameter conditioning and request intake.
module sdte_front (
   input  logic                                clock,
   input  logic                                reset,
   sdte_req_if.sink                            req,
   input  logic                                csr_we,
   input  logic [sdte_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sdte_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [1:0]                          q_count,
   output logic                                push,
   output sdte_pkg::item_type                  push_item,
   output sdte_pkg::params_type                prm
);
   import sdte_pkg::*;

   logic [1:0]  mode_ff, mode_in;
   logic [15:0] gain_ff, gain_in;
   logic [15:0] bias_ff, bias_in;
   logic [15:0] level_ff, level_in;
   logic [15:0] tone_ff, tone_in;
   params_type  prm_ff, prm_in;

   logic signed [15:0] bias_s;
   logic signed [15:0] bias_c;
   logic [15:0]        tone_c;
   logic [31:0]        tone_k;

   always_comb begin
      mode_in  = mode_ff;
      gain_in  = gain_ff;
      bias_in  = bias_ff;
      level_in = level_ff;
      tone_in  = tone_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MODE:  mode_in  = csr_wdata[1:0];
            REG_GAIN:  gain_in  = csr_wdata;
            REG_BIAS:  bias_in  = csr_wdata;
            REG_LEVEL: level_in = csr_wdata;
            REG_TONE:  tone_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp everything once, so the back end sees legal values only
   always_comb begin
      bias_s = bias_ff;
      if (bias_s > BIAS_MAX) begin
         bias_c = BIAS_MAX;
      end else if (bias_s < BIAS_MIN) begin
         bias_c = BIAS_MIN;
      end else begin
         bias_c = bias_s;
      end
      tone_c = (tone_ff > UNITY15) ? UNITY15 : tone_ff;
      tone_k = tone_c * K_095;

      prm_in.mode  = (mode_ff == MODE_SPARE) ? MODE_FOLD : mode_ff;
      prm_in.gain  = (gain_ff > UNITY15) ? UNITY15 : gain_ff;
      prm_in.bq    = {bias_c, 9'd0};
      prm_in.level = (level_ff > UNITY15) ? UNITY15 : level_ff;
      prm_in.tone  = tone_c;
      prm_in.coef  = UNITY15 - tone_k[30:15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_TANH;
         gain_ff  <= GAIN_RESET;
         bias_ff  <= 16'd0;
         level_ff <= UNITY15;
         tone_ff  <= UNITY15;
      end else begin
         mode_ff  <= mode_in;
         gain_ff  <= gain_in;
         bias_ff  <= bias_in;
         level_ff <= level_in;
         tone_ff  <= tone_in;
      end
   end

   always_ff @(posedge clock) begin
      prm_ff <= prm_in;
   end

   assign req.ready      = (q_count != 2'(QUEUE_DEPTH));
   assign push           = req.valid && req.ready;
   assign push_item.left  = req.left_sample;
   assign push_item.right = req.right_sample;
   assign push_item.last  = req.block_end;
   assign prm            = prm_ff;

endmodule

/* hdl/sdte_back.sv */
// Back end: per-channel sequencer over one shared multiplier and a radix-2 divider.
module sdte_back (
   input  logic                   clock,
   input  logic                   reset,
   input  sdte_pkg::params_type   prm,
   input  sdte_pkg::item_type     q_item,
   input  logic                   q_valid,
   output sdte_pkg::back_status_type status,
   sdte_rsp_if.source             rsp
);
   import sdte_pkg::*;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_G0   = 5'd1;
   localparam logic [4:0] ST_G1   = 5'd2;
   localparam logic [4:0] ST_G2   = 5'd3;
   localparam logic [4:0] ST_T0   = 5'd4;
   localparam logic [4:0] ST_DV   = 5'd5;
   localparam logic [4:0] ST_T1   = 5'd6;
   localparam logic [4:0] ST_T2   = 5'd7;
   localparam logic [4:0] ST_B0   = 5'd8;
   localparam logic [4:0] ST_B1   = 5'd9;
   localparam logic [4:0] ST_C0   = 5'd10;
   localparam logic [4:0] ST_C1   = 5'd11;
   localparam logic [4:0] ST_C2   = 5'd12;
   localparam logic [4:0] ST_H0   = 5'd13;
   localparam logic [4:0] ST_H1   = 5'd14;
   localparam logic [4:0] ST_F0   = 5'd15;
   localparam logic [4:0] ST_LP0  = 5'd16;
   localparam logic [4:0] ST_LP1  = 5'd17;
   localparam logic [4:0] ST_LP2  = 5'd18;
   localparam logic [4:0] ST_LP3  = 5'd19;
   localparam logic [4:0] ST_LP4  = 5'd20;
   localparam logic [4:0] ST_LP5  = 5'd21;
   localparam logic [4:0] ST_OUT  = 5'd22;
   localparam logic [4:0] QBITS_LAST = 5'd24;

   logic [4:0]         state_ff, state_in;
   logic               ch_ff, ch_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [23:0]        x_l_ff, x_l_in, x_r_ff, x_r_in;
   logic               last_ff, last_in;
   logic signed [26:0] g_ff, g_in, b_ff, b_in;
   logic signed [24:0] t_ff, t_in, h_ff, h_in, s_ff, s_in, y_ff, y_in;
   logic signed [55:0] acc_ff, acc_in, prod_ff;
   logic [28:0]        num_ff, num_in;
   logic [29:0]        den_ff, den_in;
   logic [30:0]        rem_ff, rem_in;
   logic [24:0]        q_ff, q_in;
   logic signed [24:0] llp_ff, llp_in, rlp_ff, rlp_in;
   logic [23:0]        res_l_ff, res_l_in;
   logic [23:0]        res_r_ff, res_r_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_l_ff, rsp_l_in, rsp_r_ff, rsp_r_in;
   logic               rsp_last_ff, rsp_last_in;

   logic signed [27:0] mul_a, mul_b;
   logic signed [55:0] sh13, sh15, sh23, sh24, ysum;
   logic [23:0]        x_cur;
   logic signed [24:0] st_cur, st_new;
   logic [26:0]        abs_g, x2;
   logic [29:0]        x2w;
   logic [30:0]        rem_diff;
   logic signed [28:0] cub_w;
   logic signed [25:0] lp_diff;
   logic [23:0]        sat;
   logic               pop;

   assign sh13 = prod_ff >>> 13;
   assign sh15 = prod_ff >>> 15;
   assign sh23 = prod_ff >>> 23;
   assign sh24 = prod_ff >>> 24;
   assign ysum = (acc_ff + prod_ff) >>> 15;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_comb begin
      x_cur    = ch_ff ? x_r_ff : x_l_ff;
      st_cur   = ch_ff ? rlp_ff : llp_ff;
      abs_g    = (g_ff < 0) ? 27'(-g_ff) : 27'(g_ff);
      x2       = sh23[26:0];
      x2w      = {3'd0, x2};
      rem_diff = rem_ff - {1'b0, den_ff};
      cub_w    = {{2{b_ff[26]}}, b_ff} + {b_ff[26], b_ff, 1'b0} - sh23[28:0];
      lp_diff  = {s_ff[24], s_ff} - {st_cur[24], st_cur};
      st_new   = st_cur + sh15[24:0];
      if (sh15 > 56'(ONE - 27'sd1)) begin
         sat = SAT_POS;
      end else if (sh15 < 56'(NEG_ONE)) begin
         sat = SAT_NEG;
      end else begin
         sat = sh15[23:0];
      end
   end

   always_comb begin
      state_in = state_ff;   ch_in = ch_ff;      cnt_in = cnt_ff;
      x_l_in = x_l_ff;       x_r_in = x_r_ff;    last_in = last_ff;
      g_in = g_ff;           b_in = b_ff;        t_in = t_ff;
      h_in = h_ff;           s_in = s_ff;        y_in = y_ff;
      acc_in = acc_ff;       num_in = num_ff;    den_in = den_ff;
      rem_in = rem_ff;       q_in = q_ff;        llp_in = llp_ff;
      rlp_in = rlp_ff;       res_l_in = res_l_ff; res_r_in = res_r_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_l_in = rsp_l_ff;   rsp_r_in = rsp_r_ff; rsp_last_in = rsp_last_ff;
      mul_a = '0;            mul_b = '0;         pop = 1'b0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop      = 1'b1;
               x_l_in   = q_item.left;
               x_r_in   = q_item.right;
               last_in  = q_item.last;
               ch_in    = 1'b0;
               state_in = ST_G0;
            end
         end
         ST_G0: begin
            mul_a    = {{4{x_cur[23]}}, x_cur};
            mul_b    = {12'd0, prm.gain};
            state_in = ST_G1;
         end
         ST_G1: begin
            g_in     = sh13[26:0];
            state_in = ST_G2;
         end
         ST_G2: begin
            if (prm.mode == MODE_TANH) begin
               if (g_ff > THREE) begin
                  s_in     = ONE[24:0];
                  state_in = ST_LP0;
               end else if (g_ff < NEG_THREE) begin
                  s_in     = NEG_ONE[24:0];
                  state_in = ST_LP0;
               end else begin
                  mul_a    = {1'b0, abs_g};
                  mul_b    = {1'b0, abs_g};
                  state_in = ST_T0;
               end
            end else begin
               mul_a    = {{3{prm.bq[24]}}, prm.bq};
               mul_b    = {12'd0, (prm.mode == MODE_CUBIC) ? K_02 : K_03};
               state_in = ST_B0;
            end
         end
         ST_T0: begin
            num_in   = 29'(TWENTY7_ONE + x2w);
            den_in   = TWENTY7_ONE + {x2w[26:0], 3'd0} + x2w;
            rem_in   = {2'd0, num_in};
            cnt_in   = QBITS_LAST;
            state_in = ST_DV;
         end
         ST_DV: begin
            // one quotient bit per cycle, MSB first
            if (rem_ff >= {1'b0, den_ff}) begin
               rem_in = {rem_diff[29:0], 1'b0};
               q_in   = {q_ff[23:0], 1'b1};
            end else begin
               rem_in = {rem_ff[29:0], 1'b0};
               q_in   = {q_ff[23:0], 1'b0};
            end
            if (cnt_ff == 5'd0) begin
               state_in = ST_T1;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_T1: begin
            mul_a    = {g_ff[26], g_ff};
            mul_b    = {3'd0, q_ff};
            state_in = ST_T2;
         end
         ST_T2: begin
            s_in     = sh24[24:0];
            state_in = ST_LP0;
         end
         ST_B0: begin
            b_in     = g_ff + sh15[26:0];
            state_in = ST_B1;
         end
         ST_B1: begin
            if (prm.mode == MODE_CUBIC) begin
               if (b_ff >= ONE) begin
                  s_in     = ONE[24:0];
                  state_in = ST_LP0;
               end else if (b_ff <= NEG_ONE) begin
                  s_in     = NEG_ONE[24:0];
                  state_in = ST_LP0;
               end else begin
                  mul_a    = {b_ff[26], b_ff};
                  mul_b    = {b_ff[26], b_ff};
                  state_in = ST_C0;
               end
            end else begin
               mul_a    = {b_ff[26], b_ff};
               mul_b    = {12'd0, prm.gain};
               state_in = ST_H0;
            end
         end
         ST_C0: begin
            t_in     = sh23[24:0];
            state_in = ST_C1;
         end
         ST_C1: begin
            mul_a    = {{3{t_ff[24]}}, t_ff};
            mul_b    = {b_ff[26], b_ff};
            state_in = ST_C2;
         end
         ST_C2: begin
            s_in     = cub_w[25:1];
            state_in = ST_LP0;
         end
         ST_H0: begin
            if (sh13 > 56'(ONE)) begin
               h_in = ONE[24:0];
            end else if (sh13 < 56'(NEG_ONE)) begin
               h_in = NEG_ONE[24:0];
            end else begin
               h_in = sh13[24:0];
            end
            state_in = ST_H1;
         end
         ST_H1: begin
            if (h_ff > 25'(T06)) begin
               mul_a    = {{3{h_ff[24]}}, h_ff - T06[24:0]};
               mul_b    = {12'd0, K_03};
               state_in = ST_F0;
            end else if (h_ff < 25'(NEG_T06)) begin
               mul_a    = {{3{h_ff[24]}}, h_ff + T06[24:0]};
               mul_b    = {12'd0, K_03};
               state_in = ST_F0;
            end else begin
               s_in     = h_ff;
               state_in = ST_LP0;
            end
         end
         ST_F0: begin
            s_in     = ((h_ff > 0) ? T06[24:0] : NEG_T06[24:0]) + sh15[24:0];
            state_in = ST_LP0;
         end
         ST_LP0: begin
            mul_a    = {{2{lp_diff[25]}}, lp_diff};
            mul_b    = {12'd0, prm.coef};
            state_in = ST_LP1;
         end
         ST_LP1: begin
            if (ch_ff) begin
               rlp_in = st_new;
            end else begin
               llp_in = st_new;
            end
            mul_a    = {{3{s_ff[24]}}, s_ff};
            mul_b    = {12'd0, prm.tone};
            state_in = ST_LP2;
         end
         ST_LP2: begin
            acc_in   = prod_ff;
            mul_a    = {{3{st_cur[24]}}, st_cur};
            mul_b    = {12'd0, UNITY15 - prm.tone};
            state_in = ST_LP3;
         end
         ST_LP3: begin
            y_in     = ysum[24:0];
            state_in = ST_LP4;
         end
         ST_LP4: begin
            mul_a    = {{3{y_ff[24]}}, y_ff};
            mul_b    = {12'd0, prm.level};
            state_in = ST_LP5;
         end
         ST_LP5: begin
            if (!ch_ff) begin
               res_l_in = sat;
               ch_in    = 1'b1;
               state_in = ST_G0;
            end else begin
               res_r_in = sat;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_l_in     = res_l_ff;
               rsp_r_in     = res_r_ff;
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= 1'b0;
         cnt_ff       <= 5'd0;
         llp_ff       <= '0;
         rlp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         cnt_ff       <= cnt_in;
         llp_ff       <= llp_in;
         rlp_ff       <= rlp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_l_ff <= x_l_in;   x_r_ff <= x_r_in;   last_ff <= last_in;
      g_ff <= g_in;       b_ff <= b_in;       t_ff <= t_in;
      h_ff <= h_in;       s_ff <= s_in;       y_ff <= y_in;
      acc_ff <= acc_in;   num_ff <= num_in;   den_ff <= den_in;
      rem_ff <= rem_in;   q_ff <= q_in;       res_l_ff <= res_l_in;
      res_r_ff <= res_r_in;
      rsp_l_ff <= rsp_l_in; rsp_r_ff <= rsp_r_in; rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.left_result   = rsp_l_ff;
   assign rsp.right_result  = rsp_r_ff;
   assign rsp.block_end_out = rsp_last_ff;
   assign status.busy       = (state_ff != ST_IDLE);
   assign status.pop        = pop;

endmodule
